@@ hw/rtl/mutf8_pkg.sv @@
package mutf8_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_present;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_result;
        logic [3:0] status_flags;
    } t_out_item;

    localparam int LA_DEPTH = 6;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;
    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    localparam logic [3:0] ST_INVALID   = 4'b0001;
    localparam logic [3:0] ST_TRUNC_ENC = 4'b0010;
    localparam logic [3:0] ST_UNPAIRED  = 4'b0100;
    localparam logic [3:0] ST_OUT_TRUNC = 4'b1000;

    // controller to datapath
    typedef struct packed {
        logic load;     // take input transaction into lookahead
        logic decode;   // decide head unit, load emit buffer
        logic emit;     // output one buffered byte
        logic fin;      // final status result taken: clear string state
        logic sel_fin;  // present final status on the output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       can_decode;
        logic [2:0] emit_left;
    } t_sts;

    function automatic logic is_cont(input logic [7:0] x);
        return x[7:6] == 2'b10;
    endfunction

    function automatic logic [15:0] three_cp(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        return {a[3:0], b[5:0], c[5:0]};
    endfunction

endpackage

@@ hw/rtl/mutf8_datapath.sv @@
module mutf8_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mutf8_pkg::t_in_item i_item,
    input  logic               i_at_end,
    input  logic [15:0]        i_limit,
    input  mutf8_pkg::t_cmd    i_cmd,
    output mutf8_pkg::t_sts    o_sts,
    output mutf8_pkg::t_out_item o_item
);
    import mutf8_pkg::*;

    logic [7:0]  r_la [LA_DEPTH];
    logic [2:0]  r_cnt, n_cnt;
    logic [3:0]  r_st, n_st;
    logic [15:0] r_stored, n_stored;
    logic        r_storing, n_storing;
    logic [7:0]  r_eb [4];
    logic [7:0]  n_eb [4];
    logic [2:0]  r_eleft, n_eleft;
    logic [1:0]  r_eidx, n_eidx;
    logic        r_stop, n_stop;

    logic [7:0]  b0;
    logic [2:0]  need;
    logic [15:0] cp3, low3;
    logic [20:0] cp;
    logic [3:0]  setst;
    logic [2:0]  used;
    logic        stopd;
    logic [2:0]  len;
    logic [16:0] sum;
    logic [7:0]  bb [4];

    assign b0 = r_la[0];
    assign cp3 = three_cp(r_la[0], r_la[1], r_la[2]);
    assign low3 = three_cp(r_la[3], r_la[4], r_la[5]);

    always_comb begin
        need = 3'd1;
        if (b0 >= 8'h01 && b0 <= 8'h7F) need = 3'd1;
        else if (b0[7:5] == 3'b110) need = 3'd2;
        else if (b0[7:4] == 4'hE) begin
            need = 3'd3;
            if (r_cnt >= 3'd3 && is_cont(r_la[1]) && is_cont(r_la[2])
                && cp3 >= 16'hD800 && cp3 <= 16'hDBFF) need = 3'd6;
        end else if (b0 >= 8'hF0 && b0 <= 8'hF4) need = 3'd4;
    end

    always_comb begin
        cp = REPL_CP;
        setst = '0;
        used = 3'd1;
        stopd = 1'b0;
        if (b0 >= 8'h01 && b0 <= 8'h7F) begin
            cp = {13'd0, b0};
        end else if (b0[7:5] == 3'b110) begin
            if (r_cnt < 3'd2) begin
                setst = ST_TRUNC_ENC; stopd = 1'b1;
            end else if (!is_cont(r_la[1])) begin
                setst = ST_INVALID;
            end else begin
                used = 3'd2;
                if ((b0 == 8'hC0 && r_la[1] != 8'h80) || b0 == 8'hC1) setst = ST_INVALID;
                else cp = {10'd0, b0[4:0], r_la[1][5:0]};
            end
        end else if (b0[7:4] == 4'hE) begin
            if (r_cnt < 3'd3) begin
                setst = ST_TRUNC_ENC; stopd = 1'b1;
            end else if (!is_cont(r_la[1]) || !is_cont(r_la[2])) begin
                setst = ST_INVALID;
            end else begin
                used = 3'd3;
                if (cp3 < 16'h0800) setst = ST_INVALID;
                else if (cp3 >= 16'hD800 && cp3 <= 16'hDBFF) begin
                    if (r_cnt >= 3'd6 && r_la[3][7:4] == 4'hE && is_cont(r_la[4])
                        && is_cont(r_la[5]) && low3 >= 16'hDC00 && low3 <= 16'hDFFF) begin
                        cp = 21'h10000 + {1'b0, cp3[9:0], low3[9:0]};
                        used = 3'd6;
                    end else setst = ST_UNPAIRED;
                end else if (cp3 >= 16'hDC00 && cp3 <= 16'hDFFF) setst = ST_UNPAIRED;
                else cp = {5'd0, cp3};
            end
        end else begin
            setst = ST_INVALID;
            if (b0 >= 8'hF0 && b0 <= 8'hF4 && r_cnt >= 3'd4 && is_cont(r_la[1])
                && is_cont(r_la[2]) && is_cont(r_la[3])) used = 3'd4;
        end
    end

    always_comb begin
        bb[0] = cp[7:0]; bb[1] = 8'h00; bb[2] = 8'h00; bb[3] = 8'h00;
        if (cp <= 21'h7F) len = 3'd1;
        else if (cp <= 21'h7FF) begin
            len = 3'd2;
            bb[0] = {3'b110, cp[10:6]}; bb[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            len = 3'd3;
            bb[0] = {4'hE, cp[15:12]}; bb[1] = {2'b10, cp[11:6]};
            bb[2] = {2'b10, cp[5:0]};
        end else begin
            len = 3'd4;
            bb[0] = {5'b11110, cp[20:18]}; bb[1] = {2'b10, cp[17:12]};
            bb[2] = {2'b10, cp[11:6]}; bb[3] = {2'b10, cp[5:0]};
        end
    end

    assign sum = {1'b0, r_stored} + {14'd0, len};

    always_comb begin
        n_cnt = r_cnt;
        n_st = r_st;
        n_stored = r_stored;
        n_storing = r_storing;
        n_eb = r_eb;
        n_eleft = r_eleft;
        n_eidx = r_eidx;
        n_stop = r_stop;
        if (i_cmd.load) begin
            n_stop = 1'b0;
            if (i_item.byte_present && r_cnt < 3'(LA_DEPTH)) n_cnt = r_cnt + 3'd1;
        end
        if (i_cmd.decode) begin
            n_st = r_st | setst;
            n_eidx = '0;
            n_eleft = '0;
            if (r_storing) begin
                if (sum > {1'b0, i_limit}) begin
                    n_st = r_st | setst | ST_OUT_TRUNC;
                    n_storing = 1'b0;
                end else begin
                    n_eb = bb;
                    n_eleft = len;
                    n_stored = sum[15:0];
                end
            end
            if (stopd || used >= r_cnt) n_cnt = '0;
            else n_cnt = r_cnt - used;
            n_stop = stopd;
        end
        if (i_cmd.emit) begin
            n_eidx = r_eidx + 2'd1;
            n_eleft = r_eleft - 3'd1;
        end
        if (i_cmd.fin) begin
            n_cnt = '0;
            n_st = '0;
            n_stored = '0;
            n_storing = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_st <= '0;
            r_stored <= '0;
            r_storing <= 1'b1;
            r_eleft <= '0;
            r_eidx <= '0;
            r_stop <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_st <= n_st;
            r_stored <= n_stored;
            r_storing <= n_storing;
            r_eleft <= n_eleft;
            r_eidx <= n_eidx;
            r_stop <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eb <= n_eb;
        if (i_cmd.load && i_item.byte_present && r_cnt < 3'(LA_DEPTH))
            r_la[r_cnt] <= i_item.byte_value;
        else if (i_cmd.decode) begin
            for (int k = 0; k < LA_DEPTH; k++) begin
                if (k + int'(used) < LA_DEPTH) r_la[k] <= r_la[k + int'(used)];
            end
        end
    end

    assign o_sts.can_decode = (r_cnt != 3'd0) && !r_stop && (i_at_end || r_cnt >= need);
    assign o_sts.emit_left = r_eleft;

    always_comb begin
        o_item = '0;
        if (i_cmd.sel_fin) begin
            o_item.last_result = 1'b1;
            o_item.status_flags = r_st;
        end else begin
            o_item.out_byte = r_eb[r_eidx];
            o_item.byte_valid = 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_eleft != 3'd0)
        else $error("emit with empty buffer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(LA_DEPTH))
        else $error("lookahead overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_st == '0 && r_cnt == '0)
        else $error("string state not cleared");

endmodule

@@ hw/rtl/mutf8_ctrl.sv @@
module mutf8_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_eos,
    input  logic            i_out_stall,
    input  mutf8_pkg::t_sts i_sts,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output logic            o_at_end,
    output mutf8_pkg::t_cmd o_cmd
);
    import mutf8_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_EMIT = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_end, n_end;

    always_comb begin
        n_state = r_state;
        n_end = r_end;
        o_cmd = '0;
        o_in_stall = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_end = i_in_eos;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.can_decode) begin
                    o_cmd.decode = 1'b1;
                    n_state = S_EMIT;
                end else if (r_end) n_state = S_FIN;
                else n_state = S_IDLE;
            end
            S_EMIT: begin
                if (i_sts.emit_left != 3'd0) begin
                    o_out_valid = 1'b1;
                    if (!i_out_stall) o_cmd.emit = 1'b1;
                end else n_state = S_DEC;
            end
            S_FIN: begin
                o_out_valid = 1'b1;
                o_cmd.sel_fin = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_at_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_end <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end <= n_end;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> r_end)
        else $error("final result outside string end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.decode, o_cmd.emit, o_cmd.fin}))
        else $error("conflicting commands");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decode |=> r_state == S_EMIT)
        else $error("decode not followed by emit");

endmodule

@@ hw/rtl/modified_utf8_to_utf8_transcoder.sv @@
// channel | valid       | stall       | payload
// input   | i_in_valid  | o_in_stall  | i_in_item  (t_in_item)
// output  | o_out_valid | i_out_stall | o_out_item (t_out_item)
// config  | i_cfg_we    | -           | i_cfg_data (output_byte_limit)
// one input transaction: S_IDLE loads the byte, then for each decoded unit S_DEC decodes it
// and S_EMIT outputs its 1..4 bytes (none once the output limit is hit) before going back to
// S_DEC, until S_DEC finds no further unit; at the string end S_FIN adds one status transaction
// the controller runs one input byte at a time through the lookahead and emit buffer
// reset is synchronous active low; a stalled output holds its byte and halts decoding
module modified_utf8_to_utf8_transcoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mutf8_pkg::t_in_item    i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mutf8_pkg::t_out_item   o_out_item,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_data
);
    import mutf8_pkg::*;

    logic [15:0] r_limit;
    t_cmd        cmd;
    t_sts        sts;
    logic        at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= LIMIT_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_data;
    end

    mutf8_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eos   (i_in_item.end_of_string),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_at_end   (at_end),
        .o_cmd      (cmd)
    );

    mutf8_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_in_item),
        .i_at_end(at_end),
        .i_limit(r_limit),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_item (o_out_item)
    );

endmodule

@@ tb/modified_utf8_to_utf8_transcoder_test.sv @@
module modified_utf8_to_utf8_transcoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mutf8_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;
    logic i_cfg_we;
    logic [15:0] i_cfg_data;

    modified_utf8_to_utf8_transcoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // transcoder state kept by the checker side
    logic [15:0] byte_limit;
    logic [7:0]  la_buf [LA_DEPTH];
    int          la_cnt;
    logic [3:0]  sticky;
    int          stored_cnt;
    bit          storing;

    t_out_item   expected_q[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          results_seen;
    int          strings_sent;
    int          bytes_sent;

    function automatic bit cont_byte(logic [7:0] x);
        return x[7:6] == 2'b10;
    endfunction

    function automatic logic [15:0] join3(int k);
        return {la_buf[k][3:0], la_buf[k+1][5:0], la_buf[k+2][5:0]};
    endfunction

    function automatic void queue_expected(t_out_item r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void append_byte(ref logic [7:0] s[$], input logic [7:0] b);
        s.insert(s.size(), b);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        t_out_item r;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        r.last_result = 1'b0;
        r.status_flags = 4'd0;
        queue_expected(r);
    endfunction

    function automatic void put_cp(logic [20:0] cp);
        logic [7:0] b[4];
        int n;
        if (!storing) return;
        if (cp <= 21'h7F) begin
            b[0] = cp[7:0]; n = 1;
        end else if (cp <= 21'h7FF) begin
            b[0] = 8'hC0 | cp[10:6]; b[1] = 8'h80 | cp[5:0]; n = 2;
        end else if (cp <= 21'hFFFF) begin
            b[0] = 8'hE0 | cp[15:12]; b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0]; n = 3;
        end else begin
            b[0] = 8'hF0 | cp[20:18]; b[1] = 8'h80 | cp[17:12];
            b[2] = 8'h80 | cp[11:6]; b[3] = 8'h80 | cp[5:0]; n = 4;
        end
        if (stored_cnt + n > int'(byte_limit)) begin
            sticky |= ST_OUT_TRUNC;
            storing = 1'b0;
            return;
        end
        for (int k = 0; k < n; k++) push_byte(b[k]);
        stored_cnt += n;
    endfunction

    function automatic int needed_bytes();
        logic [7:0] b0;
        logic [15:0] cp;
        b0 = la_buf[0];
        if (b0 >= 8'h01 && b0 <= 8'h7F) return 1;
        if (b0[7:5] == 3'b110) return 2;
        if (b0[7:4] == 4'hE) begin
            if (la_cnt < 3) return 3;
            if (!cont_byte(la_buf[1]) || !cont_byte(la_buf[2])) return 3;
            cp = join3(0);
            if (cp >= 16'hD800 && cp <= 16'hDBFF) return 6;
            return 3;
        end
        if (b0 >= 8'hF0 && b0 <= 8'hF4) return 4;
        return 1;
    endfunction

    // returns bytes consumed, -1 stops the string
    function automatic int decode_unit();
        logic [7:0] b0;
        logic [15:0] cp, lo;
        b0 = la_buf[0];
        if (b0 >= 8'h01 && b0 <= 8'h7F) begin
            put_cp({13'd0, b0});
            return 1;
        end
        if (b0[7:5] == 3'b110) begin
            if (la_cnt < 2) begin
                sticky |= ST_TRUNC_ENC; put_cp(REPL_CP); return -1;
            end
            if (!cont_byte(la_buf[1])) begin
                sticky |= ST_INVALID; put_cp(REPL_CP); return 1;
            end
            cp = {5'd0, b0[4:0], la_buf[1][5:0]};
            if ((b0 == 8'hC0 && la_buf[1] != 8'h80) || b0 == 8'hC1
                || (cp != 0 && cp < 16'h80)) begin
                sticky |= ST_INVALID; put_cp(REPL_CP); return 2;
            end
            put_cp({5'd0, cp});
            return 2;
        end
        if (b0[7:4] == 4'hE) begin
            if (la_cnt < 3) begin
                sticky |= ST_TRUNC_ENC; put_cp(REPL_CP); return -1;
            end
            if (!cont_byte(la_buf[1]) || !cont_byte(la_buf[2])) begin
                sticky |= ST_INVALID; put_cp(REPL_CP); return 1;
            end
            cp = join3(0);
            if (cp < 16'h800) begin
                sticky |= ST_INVALID; put_cp(REPL_CP); return 3;
            end
            if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                if (la_cnt >= 6 && la_buf[3][7:4] == 4'hE && cont_byte(la_buf[4])
                    && cont_byte(la_buf[5])) begin
                    lo = join3(3);
                    if (lo >= 16'hDC00 && lo <= 16'hDFFF) begin
                        put_cp(21'h10000 + ({5'd0, cp - 16'hD800} << 10)
                               + {5'd0, lo - 16'hDC00});
                        return 6;
                    end
                end
                sticky |= ST_UNPAIRED; put_cp(REPL_CP); return 3;
            end
            if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                sticky |= ST_UNPAIRED; put_cp(REPL_CP); return 3;
            end
            put_cp({5'd0, cp});
            return 3;
        end
        sticky |= ST_INVALID;
        put_cp(REPL_CP);
        if (b0 >= 8'hF0 && b0 <= 8'hF4 && la_cnt >= 4 && cont_byte(la_buf[1])
            && cont_byte(la_buf[2]) && cont_byte(la_buf[3]))
            return 4;
        return 1;
    endfunction

    function automatic void clear_string();
        la_cnt = 0;
        sticky = 4'd0;
        stored_cnt = 0;
        storing = 1'b1;
    endfunction

    function automatic void predict_transcode(t_in_item it);
        int used;
        t_out_item r;
        if (it.byte_present && la_cnt < LA_DEPTH) begin
            la_buf[la_cnt] = it.byte_value;
            la_cnt++;
        end
        while (la_cnt > 0) begin
            if (!it.end_of_string && la_cnt < needed_bytes()) break;
            used = decode_unit();
            if (used < 0 || used >= la_cnt) begin
                la_cnt = 0;
                if (used < 0) break;
            end else begin
                for (int k = 0; k + used < la_cnt; k++) la_buf[k] = la_buf[k+used];
                la_cnt -= used;
            end
        end
        if (it.end_of_string) begin
            r.out_byte = 8'd0;
            r.byte_valid = 1'b0;
            r.last_result = 1'b1;
            r.status_flags = sticky;
            queue_expected(r);
            clear_string();
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", o_out_item);
            end else begin
                exp_item = expected_q.pop_front();
                if (o_out_item.out_byte !== exp_item.out_byte
                    || o_out_item.byte_valid !== exp_item.byte_valid
                    || o_out_item.last_result !== exp_item.last_result
                    || o_out_item.status_flags !== exp_item.status_flags) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected byte %h valid %b last %b flags %h, ",
                                 exp_item.out_byte, exp_item.byte_valid,
                                 exp_item.last_result, exp_item.status_flags,
                                 "got byte %h valid %b last %b flags %h",
                                 o_out_item.out_byte, o_out_item.byte_valid,
                                 o_out_item.last_result, o_out_item.status_flags);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(logic [7:0] val, bit present, bit last);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        it.byte_value = val;
        it.byte_present = present;
        it.end_of_string = last;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_transcode(it);
        bytes_sent++;
        if (last) strings_sent++;
    endtask

    task automatic send_string(logic [7:0] s[$]);
        for (int k = 0; k < s.size(); k++) send_item(s[k], 1'b1, k == s.size() - 1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        byte_limit = v;
    endtask

    task automatic test_directed();
        send_string('{8'h41, 8'h7F, 8'h01});
        send_string('{8'hC0, 8'h80, 8'h00, 8'hC1, 8'hBF, 8'hC2, 8'h80, 8'hDF, 8'hBF});
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
        send_string('{8'hED, 8'hA0, 8'hBD, 8'hED, 8'hB8, 8'h80});
        send_string('{8'hED, 8'hB0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'h41});
        send_string('{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hE2, 8'h41});
        send_string('{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF5, 8'hFF, 8'h80});
        send_string('{8'h41, 8'hC3});
        send_string('{8'hE2, 8'h82});
    endtask

    function automatic void add_unit(ref logic [7:0] s[$]);
        logic [15:0] cp;
        case ($urandom_range(9))
            0, 1: append_byte(s, 8'($urandom_range(1, 127)));
            2: begin
                cp = 16'($urandom_range(16'h80, 16'h7FF));
                append_byte(s, 8'hC0 | cp[10:6]); append_byte(s, 8'h80 | cp[5:0]);
            end
            3: begin
                cp = 16'($urandom_range(16'h800, 16'hFFFF));
                append_byte(s, 8'hE0 | cp[15:12]); append_byte(s, 8'h80 | cp[11:6]);
                append_byte(s, 8'h80 | cp[5:0]);
            end
            4, 5: begin
                cp = 16'($urandom_range(16'hD800, 16'hDBFF));
                append_byte(s, 8'hE0 | cp[15:12]); append_byte(s, 8'h80 | cp[11:6]);
                append_byte(s, 8'h80 | cp[5:0]);
                if ($urandom_range(4) != 0) begin
                    cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
                    append_byte(s, 8'hE0 | cp[15:12]); append_byte(s, 8'h80 | cp[11:6]);
                    append_byte(s, 8'h80 | cp[5:0]);
                end
            end
            6: begin
                append_byte(s, 8'hC0); append_byte(s, 8'h80);
            end
            7: begin
                append_byte(s, 8'($urandom_range(8'hF0, 8'hF4)));
                repeat (3) append_byte(s, 8'h80 | 8'($urandom_range(63)));
            end
            default: append_byte(s, 8'($urandom_range(255)));
        endcase
    endfunction

    task automatic test_random(int budget);
        logic [7:0] s[$];
        while (budget > 0) begin
            s.delete();
            if ($urandom_range(15) == 0) begin
                send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
                continue;
            end
            repeat ($urandom_range(1, 5)) add_unit(s);
            if (s.size() > 20) s = s[0:19];
            if ($urandom_range(7) == 0) append_byte(s, 8'($urandom_range(8'hC0, 8'hEF)));
            if ($urandom_range(9) == 0) begin
                send_item(s[0], 1'b1, 1'b0);
                send_item(8'($urandom_range(255)), 1'b0, 1'b1);
                budget -= 2;
            end else begin
                send_string(s);
                budget -= s.size();
            end
        end
    endtask

    task automatic test_limits();
        set_limit(16'd4);
        test_random(60);
        set_limit(16'd0);
        send_string('{8'h41, 8'h42});
        set_limit(16'hFFFF);
        test_random(40);
        set_limit(16'd7);
        test_random(60);
        set_limit(LIMIT_RESET);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        byte_limit = LIMIT_RESET;
        for (int k = 0; k < LA_DEPTH; k++) la_buf[k] = '0;
        clear_string();
        mismatches = 0;
        results_seen = 0;
        strings_sent = 0;
        bytes_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 13;
        recv_idle_pct = 85;
        test_random(110);
        drain();
        send_idle_pct = 85;
        recv_idle_pct = 13;
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_limits();
        test_random(30);
        drain();

        $display("covered %0d input transactions in %0d strings, %0d output transactions",
                 bytes_sent, strings_sent, results_seen);
        $display("limits 0, 4, 7, 4096 and 65535 with mixed stall patterns");
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("modified_utf8_to_utf8_transcoder_test: PASS");
        end else begin
            $display("modified_utf8_to_utf8_transcoder_test: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("modified_utf8_to_utf8_transcoder_test: FAIL");
        $finish;
    end
endmodule
